>>> sv/uerm_pkg.sv
`default_nettype none

package uerm_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_TRIG_WIDTH = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd2;
  localparam logic [2:0] CFG_SPEED      = 3'd3;
  localparam logic [2:0] CFG_MIN_MM     = 3'd4;
  localparam logic [2:0] CFG_MAX_MM     = 3'd5;
  localparam logic [2:0] CFG_WIN_LEN    = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    ST_NONE          = 3'd0,
    ST_VALID         = 3'd1,
    ST_NOT_STARTED   = 3'd2,
    ST_START_TIMEOUT = 3'd3,
    ST_END_TIMEOUT   = 3'd4,
    ST_NO_ECHO       = 3'd5,
    ST_RANGE         = 3'd6
  } status_t;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } in_word_t;

  typedef struct packed {
    logic        trigger_level;
    logic        done_res;
    status_t     status;
    logic [15:0] raw_mm;
    logic [15:0] filtered_mm;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic mul;
    logic div;
    logic check;
    logic med_init;
    logic cand;
    logic sweep;
    logic eval;
    logic load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finish;
    logic keep;
    logic sweep_done;
    logic med_hit;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/uerm_stream_if.sv
`default_nettype none

interface uerm_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/ultrasonic_echo_ranger_median_core.sv
`default_nettype none

// channel   dir  payload                                               handshake
// tick      in   start_request, echo_level                             valid/ready
// result    out  trigger_level, done_res, status, raw_mm, filtered_mm  valid/ready
// cfg       in   cfg_index, cfg_data                                   cfg_we, no wait
//
// One result word per tick word. A plain tick passes the accept and load states.
// A finished echo adds a multiply state, a reciprocal-multiply divide state and a
// check state; a kept distance adds median rank counting (candidate, sweep, eval)
// over the n window words (two registered read ports of the history memory).
// Reset is synchronous, clears sequencer and window pointers, loads config defaults.
// A tick is taken while the previous result still waits; a stalled result
// holds the next one in the load state.
module ultrasonic_echo_ranger_median_core #(
  parameter int MAX_WINDOW = 16,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  uerm_stream_if.sink                          tick,
  uerm_stream_if.source                        result,
  input  wire logic                            cfg_we,
  input  wire logic [uerm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uerm_pkg::CFG_DATA_W-1:0] cfg_data
);

  uerm_pkg::cmd_t      cmd;
  uerm_pkg::stat_t     st;
  uerm_pkg::in_word_t  in_word;
  uerm_pkg::out_word_t out_word;

  assign in_word     = tick.data;
  assign result.data = out_word;

  uerm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .st        (st),
    .cmd       (cmd)
  );

  uerm_dp #(
    .MAXW (MAX_WINDOW),
    .TB   (TIMER_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start_request (in_word.start_request),
    .echo_level    (in_word.echo_level),
    .cmd           (cmd),
    .st            (st),
    .word          (out_word)
  );

`ifndef SYNTHESIS
  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!result.valid || result.ready))
    else $error("result word overwritten before it was taken");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> result.valid)
    else $error("loaded result word not presented");

  a_done_status: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.done_res == (result.data.status != uerm_pkg::ST_NONE)))
    else $error("done flag and status disagree");

  a_filt_only_valid: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.status != uerm_pkg::ST_VALID)
      |-> (result.data.filtered_mm == 16'd0))
    else $error("median reported without a kept distance");
`endif

endmodule

`default_nettype wire

>>> sv/uerm_ctrl.sv
`default_nettype none

module uerm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire uerm_pkg::stat_t st,
  output uerm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CHECK,
    S_MED_INIT,
    S_MED_CAND,
    S_MED_SWEEP,
    S_MED_EVAL,
    S_LOAD
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.mul      = (state == S_MUL);
    cmd.div      = (state == S_DIV);
    cmd.check    = (state == S_CHECK);
    cmd.med_init = (state == S_MED_INIT);
    cmd.cand     = (state == S_MED_CAND);
    cmd.sweep    = (state == S_MED_SWEEP);
    cmd.eval     = (state == S_MED_EVAL);
    cmd.load     = (state == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= st.finish ? S_MUL : S_LOAD;
          end
        end
        S_MUL:      state <= S_DIV;
        S_DIV:      state <= S_CHECK;
        S_CHECK:    state <= st.keep ? S_MED_INIT : S_LOAD;
        S_MED_INIT: state <= S_MED_CAND;
        S_MED_CAND: state <= S_MED_SWEEP;
        S_MED_SWEEP: begin
          if (st.sweep_done) state <= S_MED_EVAL;
        end
        S_MED_EVAL: state <= st.med_hit ? S_LOAD : S_MED_CAND;
        S_LOAD: begin
          if (out_free) state <= S_IDLE;
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/uerm_dp.sv
`default_nettype none

module uerm_dp #(
  parameter int MAXW = 16,
  parameter int TB   = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [uerm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [uerm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                start_request,
  input  wire logic                                echo_level,
  input  wire uerm_pkg::cmd_t                      cmd,
  output uerm_pkg::stat_t                          st,
  output uerm_pkg::out_word_t                      word
);

  localparam int AW  = (MAXW > 1) ? $clog2(MAXW) : 1;
  localparam int CW  = $clog2(MAXW + 1);
  localparam int PW  = TB + 10;
  localparam int PX  = (PW > 27) ? PW : 27;
  localparam int LW  = (TB > 16) ? TB : 16;
  localparam logic [TB-1:0] TMAX     = '1;
  // 65536 * 2000: any product from here up saturates the distance
  localparam logic [PX-1:0] SAT_PROD = PX'(131072000);
  // ceil(2^30 / 125)
  localparam logic [23:0]   RECIP    = 24'd8589935;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW,
    PH_HIGH,
    PH_WAIT_START,
    PH_WAIT_END
  } phase_t;

  // configuration
  logic        enable;
  logic [7:0]  trig_width;
  logic [15:0] timeout;
  logic [9:0]  speed;
  logic [15:0] min_mm;
  logic [15:0] max_mm;
  logic [4:0]  win_len;

  // sequencer state
  phase_t        phase, phase_next;
  logic [TB-1:0] tick_cnt, tick_next;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] fill;

  // tick evaluation
  logic             e_trig, e_done, e_finish;
  uerm_pkg::status_t e_status;
  logic [7:0]       width_e;
  logic [LW-1:0]    lim_w;
  logic [TB-1:0]    lim, cnt_up;

  // result under construction
  logic             r_trig, r_done;
  uerm_pkg::status_t r_status;
  logic [15:0]      r_raw, r_filt;

  // distance
  logic [TB-1:0]  dur;
  logic [PW-1:0]  prod;
  logic [PX-1:0]  prod_x;
  logic [22:0]    div_n;
  logic [46:0]    div_p;
  logic           prod_big;
  logic           no_echo;
  logic [15:0]    q_sat;
  logic           in_range, keep;

  // window
  logic [15:0]   hist [MAXW];
  logic [CW-1:0] len_e;
  logic [CW:0]   fill_inc;
  logic [CW-1:0] fill_next;
  logic [AW+1:0] ws_ext, n_ext, s0_w;
  logic [AW-1:0] s0, base, cand_addr, sw_addr;
  logic [15:0]   cand_q, sw_q;
  logic [CW-1:0] j, less, leq, k;
  logic          rd_pend, hit;

  function automatic logic [AW-1:0] slot_step(input logic [AW-1:0] a);
    return (a == AW'(MAXW - 1)) ? '0 : a + 1'b1;
  endfunction

  always_comb begin
    width_e   = (trig_width == 8'd0) ? 8'd1 : trig_width;
    lim_w     = (timeout == 16'd0) ? LW'(1) : LW'(timeout);
    lim       = (lim_w > LW'(TMAX)) ? TMAX : TB'(lim_w);
    cnt_up    = (tick_cnt == TMAX) ? tick_cnt : tick_cnt + 1'b1;
    phase_next = phase;
    tick_next  = tick_cnt;
    e_trig     = 1'b0;
    e_done     = 1'b0;
    e_finish   = 1'b0;
    e_status   = uerm_pkg::ST_NONE;
    case (phase)
      PH_IDLE: begin
        if (start_request) begin
          if (!enable) begin
            e_done   = 1'b1;
            e_status = uerm_pkg::ST_NOT_STARTED;
          end else begin
            phase_next = PH_LOW;
            tick_next  = '0;
          end
        end
      end
      PH_LOW: begin
        phase_next = PH_HIGH;
        tick_next  = '0;
      end
      PH_HIGH: begin
        e_trig    = 1'b1;
        tick_next = cnt_up;
        if (cnt_up >= TB'(width_e)) begin
          phase_next = PH_WAIT_START;
          tick_next  = '0;
        end
      end
      PH_WAIT_START: begin
        if (echo_level) begin
          phase_next = PH_WAIT_END;
          tick_next  = TB'(1);
        end else begin
          tick_next = cnt_up;
          if (cnt_up >= lim) begin
            e_done     = 1'b1;
            e_status   = uerm_pkg::ST_START_TIMEOUT;
            phase_next = PH_IDLE;
            tick_next  = '0;
          end
        end
      end
      PH_WAIT_END: begin
        if (!echo_level) begin
          e_done     = 1'b1;
          e_finish   = 1'b1;
          phase_next = PH_IDLE;
          tick_next  = '0;
        end else begin
          tick_next = cnt_up;
          if (cnt_up >= lim) begin
            e_done     = 1'b1;
            e_status   = uerm_pkg::ST_END_TIMEOUT;
            phase_next = PH_IDLE;
            tick_next  = '0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        tick_next  = '0;
      end
    endcase
  end

  always_comb begin
    prod_x   = PX'(prod);
    prod_big = (prod_x >= SAT_PROD);
    // x / 2000 = (x >> 4) / 125; the reciprocal is exact below SAT_PROD
    div_n    = prod_x[26:4];
    div_p    = 47'(div_n) * 47'(RECIP);
    in_range = !((q_sat < min_mm) || (q_sat > max_mm));
    keep     = !no_echo && in_range;

    if (win_len == 5'd0) begin
      len_e = CW'(1);
    end else if (32'(win_len) > MAXW) begin
      len_e = CW'(MAXW);
    end else begin
      len_e = CW'(win_len);
    end
    fill_inc  = {1'b0, fill} + 1'b1;
    fill_next = (fill_inc > {1'b0, len_e}) ? len_e : fill_inc[CW-1:0];

    // oldest kept slot
    ws_ext = (AW+2)'(write_slot);
    n_ext  = (AW+2)'(fill);
    s0_w   = (ws_ext >= n_ext) ? ws_ext - n_ext : ws_ext + (AW+2)'(MAXW) - n_ext;
    s0     = s0_w[AW-1:0];

    k   = fill >> 1;
    hit = (less <= k) && (leq > k);
  end

  assign st.finish     = e_finish;
  assign st.keep       = keep;
  assign st.sweep_done = (j == fill) && !rd_pend;
  assign st.med_hit    = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      trig_width <= 8'd10;
      timeout    <= 16'd30000;
      speed      <= 10'd343;
      min_mm     <= 16'd20;
      max_mm     <= 16'd4000;
      win_len    <= 5'd5;
      phase      <= PH_IDLE;
      tick_cnt   <= '0;
      write_slot <= '0;
      fill       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          uerm_pkg::CFG_ENABLE:     enable     <= cfg_data[0];
          uerm_pkg::CFG_TRIG_WIDTH: trig_width <= cfg_data[7:0];
          uerm_pkg::CFG_TIMEOUT:    timeout    <= cfg_data;
          uerm_pkg::CFG_SPEED:      speed      <= cfg_data[9:0];
          uerm_pkg::CFG_MIN_MM:     min_mm     <= cfg_data;
          uerm_pkg::CFG_MAX_MM:     max_mm     <= cfg_data;
          uerm_pkg::CFG_WIN_LEN:    win_len    <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        phase    <= phase_next;
        tick_cnt <= tick_next;
      end
      if (cmd.check && keep) begin
        write_slot <= slot_step(write_slot);
        fill       <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_trig   <= e_trig;
      r_done   <= e_done;
      r_status <= e_status;
      r_raw    <= '0;
      r_filt   <= '0;
      dur      <= tick_cnt;
    end
    if (cmd.mul) begin
      prod    <= {{10{1'b0}}, dur} * {{TB{1'b0}}, speed};
      no_echo <= (dur == '0) || (speed == 10'd0);
    end
    if (cmd.div) begin
      q_sat <= prod_big ? 16'hFFFF : div_p[45:30];
    end
    if (cmd.check) begin
      if (no_echo) begin
        r_status <= uerm_pkg::ST_NO_ECHO;
      end else begin
        r_raw    <= q_sat;
        r_status <= in_range ? uerm_pkg::ST_VALID : uerm_pkg::ST_RANGE;
      end
    end
    if (cmd.med_init) begin
      base      <= s0;
      cand_addr <= s0;
    end
    if (cmd.cand) begin
      sw_addr <= base;
      j       <= '0;
      rd_pend <= 1'b0;
      less    <= '0;
      leq     <= '0;
    end
    // rank count of the candidate against every kept word
    if (cmd.sweep) begin
      if (rd_pend) begin
        if (sw_q < cand_q)  less <= less + 1'b1;
        if (sw_q <= cand_q) leq  <= leq + 1'b1;
      end
      if (j != fill) begin
        sw_addr <= slot_step(sw_addr);
        j       <= j + 1'b1;
        rd_pend <= 1'b1;
      end else begin
        rd_pend <= 1'b0;
      end
    end
    if (cmd.eval) begin
      if (hit) begin
        r_filt <= cand_q;
      end else begin
        cand_addr <= slot_step(cand_addr);
      end
    end
    if (cmd.load) begin
      word.trigger_level <= r_trig;
      word.done_res      <= r_done;
      word.status        <= r_status;
      word.raw_mm        <= r_raw;
      word.filtered_mm   <= r_filt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && keep) begin
      hist[write_slot] <= q_sat;
    end
    cand_q <= hist[cand_addr];
    sw_q   <= hist[sw_addr];
  end

endmodule

`default_nettype wire

>>> dv/tb_ultrasonic_echo_ranger_median_core.sv
`timescale 1ns / 1ps

class echo_range_scoreboard;
  localparam int unsigned WIN_MAX = 16;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LOW,
    SEQ_HIGH,
    SEQ_WAIT_RISE,
    SEQ_WAIT_FALL
  } seq_t;

  // register copies
  bit          enabled;
  bit [7:0]    trig_width;
  bit [15:0]   echo_timeout;
  bit [9:0]    speed;
  bit [15:0]   min_mm;
  bit [15:0]   max_mm;
  bit [4:0]    win_len;

  // ranging state
  seq_t        seq;
  int unsigned ticks;
  bit [15:0]   hist [WIN_MAX];
  int unsigned wr_slot;
  int unsigned fill;

  uerm_pkg::out_word_t expected_q[$];
  int unsigned         errors;

  function new();
    enabled      = 1'b0;
    trig_width   = 8'd10;
    echo_timeout = 16'd30000;
    speed        = 10'd343;
    min_mm       = 16'd20;
    max_mm       = 16'd4000;
    win_len      = 5'd5;
    seq          = SEQ_IDLE;
    ticks        = 0;
    wr_slot      = 0;
    fill         = 0;
    errors       = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] d);
    case (idx)
      uerm_pkg::CFG_ENABLE:     enabled      = d[0];
      uerm_pkg::CFG_TRIG_WIDTH: trig_width   = d[7:0];
      uerm_pkg::CFG_TIMEOUT:    echo_timeout = d;
      uerm_pkg::CFG_SPEED:      speed        = d[9:0];
      uerm_pkg::CFG_MIN_MM:     min_mm       = d;
      uerm_pkg::CFG_MAX_MM:     max_mm       = d;
      uerm_pkg::CFG_WIN_LEN:    win_len      = d[4:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function int unsigned count_up(int unsigned c);
    return (c >= 32'hFFFF) ? 32'hFFFF : c + 1;
  endfunction

  function void note_tick(uerm_pkg::in_word_t w);
    uerm_pkg::out_word_t o;
    int unsigned width, limit, mm, len, slot, i, j;
    bit [15:0]   vals [WIN_MAX];
    bit [15:0]   v;
    o = '0;
    width = (trig_width == 0) ? 1 : trig_width;
    limit = (echo_timeout == 0) ? 1 : echo_timeout;
    case (seq)
      SEQ_IDLE: begin
        if (w.start_request) begin
          if (!enabled) begin
            o.done_res = 1'b1;
            o.status   = uerm_pkg::ST_NOT_STARTED;
          end else begin
            seq   = SEQ_LOW;
            ticks = 0;
          end
        end
      end
      SEQ_LOW: begin
        seq   = SEQ_HIGH;
        ticks = 0;
      end
      SEQ_HIGH: begin
        o.trigger_level = 1'b1;
        ticks = count_up(ticks);
        if (ticks >= width) begin
          seq   = SEQ_WAIT_RISE;
          ticks = 0;
        end
      end
      SEQ_WAIT_RISE: begin
        if (w.echo_level) begin
          seq   = SEQ_WAIT_FALL;
          ticks = 1;
        end else begin
          ticks = count_up(ticks);
          if (ticks >= limit) begin
            o.done_res = 1'b1;
            o.status   = uerm_pkg::ST_START_TIMEOUT;
            seq        = SEQ_IDLE;
            ticks      = 0;
          end
        end
      end
      SEQ_WAIT_FALL: begin
        if (!w.echo_level) begin
          o.done_res = 1'b1;
          if (ticks == 0 || speed == 0) begin
            o.status = uerm_pkg::ST_NO_ECHO;
          end else begin
            mm = ticks * speed / 2000;
            if (mm > 32'hFFFF) mm = 32'hFFFF;
            o.raw_mm = mm[15:0];
            if (mm < min_mm || mm > max_mm) begin
              o.status = uerm_pkg::ST_RANGE;
            end else begin
              len = (win_len == 0) ? 1 : ((win_len > WIN_MAX) ? WIN_MAX : win_len);
              hist[wr_slot] = mm[15:0];
              wr_slot = (wr_slot + 1) % WIN_MAX;
              fill = (fill + 1 > len) ? len : fill + 1;
              // newest first, then insertion sort; upper median
              slot = wr_slot;
              for (i = 0; i < fill; i++) begin
                slot = (slot + WIN_MAX - 1) % WIN_MAX;
                vals[i] = hist[slot];
              end
              for (i = 1; i < fill; i++) begin
                v = vals[i];
                j = i;
                while (j > 0 && vals[j-1] > v) begin
                  vals[j] = vals[j-1];
                  j--;
                end
                vals[j] = v;
              end
              o.status      = uerm_pkg::ST_VALID;
              o.filtered_mm = vals[fill/2];
            end
          end
          seq   = SEQ_IDLE;
          ticks = 0;
        end else begin
          ticks = count_up(ticks);
          if (ticks >= limit) begin
            o.done_res = 1'b1;
            o.status   = uerm_pkg::ST_END_TIMEOUT;
            seq        = SEQ_IDLE;
            ticks      = 0;
          end
        end
      end
      default: begin
        seq   = SEQ_IDLE;
        ticks = 0;
      end
    endcase
    expected_q.insert(expected_q.size(), o);
  endfunction

  function void check_field(string name, logic [15:0] e, logic [15:0] g);
    if (g !== e) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, g);
      errors++;
    end
  endfunction

  function void check_result(uerm_pkg::out_word_t got);
    uerm_pkg::out_word_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: result word with nothing expected, expected none, got %0h",
               $time, got);
      errors++;
      return;
    end
    e = expected_q[0];
    expected_q.delete(0);
    check_field("trigger_level", e.trigger_level, got.trigger_level);
    check_field("done_res", e.done_res, got.done_res);
    check_field("status", e.status, got.status);
    check_field("raw_mm", e.raw_mm, got.raw_mm);
    check_field("filtered_mm", e.filtered_mm, got.filtered_mm);
  endfunction
endclass

module tb_ultrasonic_echo_ranger_median_core;

  localparam int unsigned SETTLE_CYCLES = 400;   // worst median pass plus divide
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned TARGET_TICKS  = 760;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                            cfg_we;
  logic [uerm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [uerm_pkg::CFG_DATA_W-1:0] cfg_data;

  uerm_stream_if #(.word_t(uerm_pkg::in_word_t))  tick_if ();
  uerm_stream_if #(.word_t(uerm_pkg::out_word_t)) result_if ();

  ultrasonic_echo_ranger_median_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  echo_range_scoreboard sb;
  int unsigned sent;
  int unsigned quiet;
  bit          steady;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitors
  always @(posedge clk) begin
    if (!rst && cfg_we) sb.write_reg(cfg_index, cfg_data);
    if (!rst && tick_if.valid && tick_if.ready) sb.note_tick(tick_if.data);
    if (!rst && result_if.valid && result_if.ready) sb.check_result(result_if.data);
  end

  // receiver back-pressure
  always @(negedge clk) begin
    result_if.ready = steady ? 1'b1 : ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (tick_if.valid && tick_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic push_tick(bit start, bit echo);
    while (!steady && $urandom_range(99) < 24) begin
      tick_if.valid = 1'b0;
      @(negedge clk);
    end
    tick_if.valid = 1'b1;
    tick_if.data  = '{start_request: start, echo_level: echo};
    do @(posedge clk); while (!tick_if.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [uerm_pkg::CFG_IDX_W-1:0] idx,
                           logic [uerm_pkg::CFG_DATA_W-1:0] d);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic await_results();
    tick_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic settle();
    await_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // start, trigger ticks (start bits ignored while busy), echo wait, echo pulse, fall
  task automatic run_echo(int unsigned low_gap, int unsigned high_len);
    int unsigned w;
    w = (sb.trig_width == 0) ? 1 : sb.trig_width;
    push_tick(1'b1, 1'($urandom_range(1)));
    repeat (w + 1) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (low_gap) push_tick(1'b0, 1'b0);
    repeat (high_len) push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
  endtask

  task automatic shaped_echo(int unsigned max_high);
    int unsigned lim, gap, high;
    lim  = (sb.echo_timeout == 0) ? 1 : sb.echo_timeout;
    gap  = ($urandom_range(99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, lim + 1);
    high = ($urandom_range(99) < 80) ? $urandom_range(1, max_high)
                                     : $urandom_range(1, lim + 2);
    run_echo(gap, high);
    // noise and broken sequences
    repeat ($urandom_range(0, 2)) push_tick($urandom_range(99) < 25, 1'($urandom_range(1)));
    if ($urandom_range(99) < 5) await_results();
  endtask

  task automatic random_config();
    write_reg(uerm_pkg::CFG_ENABLE, ($urandom_range(99) < 85) ? 16'd1 : 16'd0);
    write_reg(uerm_pkg::CFG_TRIG_WIDTH,
              ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(1, 3)));
    write_reg(uerm_pkg::CFG_TIMEOUT, 16'($urandom_range(3, 30)));
    write_reg(uerm_pkg::CFG_SPEED, 16'($urandom_range(150, 1023)));
    write_reg(uerm_pkg::CFG_MIN_MM, 16'($urandom_range(0, 3)));
    write_reg(uerm_pkg::CFG_MAX_MM,
              ($urandom_range(1) != 0) ? 16'hFFFF : 16'($urandom_range(4, 15)));
    write_reg(uerm_pkg::CFG_WIN_LEN, 16'($urandom_range(1, 16)));
  endtask

  initial begin
    int unsigned phase_start, n;
    sb            = new();
    steady        = 1'b0;
    sent          = 0;
    quiet         = 0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tick_if.valid = 1'b0;
    tick_if.data  = '0;
    result_if.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // reset values: disabled, so starts report not started
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    settle();

    // zero width, zero timeout, zero window length all act as one
    write_reg(uerm_pkg::CFG_ENABLE, 16'd1);
    write_reg(uerm_pkg::CFG_TRIG_WIDTH, 16'd0);
    write_reg(uerm_pkg::CFG_TIMEOUT, 16'd0);
    write_reg(uerm_pkg::CFG_SPEED, 16'd1023);
    write_reg(uerm_pkg::CFG_MIN_MM, 16'd0);
    write_reg(uerm_pkg::CFG_MAX_MM, 16'hFFFF);
    write_reg(uerm_pkg::CFG_WIN_LEN, 16'd0);
    run_echo(0, 1);
    run_echo(1, 0);
    run_echo(0, 3);
    // clearing enable mid-measurement must not stop it
    push_tick(1'b1, 1'b0);
    settle();
    write_reg(uerm_pkg::CFG_ENABLE, 16'd0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    settle();

    // widest trigger, longest timeout, zero speed gives no echo
    write_reg(uerm_pkg::CFG_ENABLE, 16'd1);
    write_reg(uerm_pkg::CFG_TRIG_WIDTH, 16'd255);
    write_reg(uerm_pkg::CFG_TIMEOUT, 16'hFFFF);
    write_reg(uerm_pkg::CFG_SPEED, 16'd0);
    run_echo(2, 3);
    settle();

    // min above max: nothing is ever kept
    write_reg(uerm_pkg::CFG_TRIG_WIDTH, 16'd1);
    write_reg(uerm_pkg::CFG_TIMEOUT, 16'd12);
    write_reg(uerm_pkg::CFG_SPEED, 16'd1023);
    write_reg(uerm_pkg::CFG_MIN_MM, 16'd100);
    write_reg(uerm_pkg::CFG_MAX_MM, 16'd50);
    repeat (3) shaped_echo(12);
    settle();

    // oversized window acts as the full 16
    write_reg(uerm_pkg::CFG_TRIG_WIDTH, 16'd2);
    write_reg(uerm_pkg::CFG_TIMEOUT, 16'd12);
    write_reg(uerm_pkg::CFG_MIN_MM, 16'd0);
    write_reg(uerm_pkg::CFG_MAX_MM, 16'hFFFF);
    write_reg(uerm_pkg::CFG_WIN_LEN, 16'd31);
    repeat (18) shaped_echo(8);
    settle();

    // shrink a full window: oldest words drop out
    write_reg(uerm_pkg::CFG_WIN_LEN, 16'd3);
    repeat (4) shaped_echo(20);
    settle();

    n = 0;
    do begin
      random_config();
      steady = (n == 0);
      phase_start = sent;
      while (sent - phase_start < 70) shaped_echo(12);
      settle();
      steady = 1'b0;
      n++;
    end while (sent < TARGET_TICKS);
    write_reg(uerm_pkg::CFG_WIN_LEN, 16'd16);
    write_reg(uerm_pkg::CFG_MIN_MM, 16'd0);
    write_reg(uerm_pkg::CFG_MAX_MM, 16'hFFFF);
    repeat (6) shaped_echo(12);

    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
